### design/rhms_pkg.sv
// Types, constants and elaboration-time tables shared by the rolling hash sketch.
package rhms_pkg;

	localparam int HashW = 30;
	localparam int FeatW = 32;
	localparam int NumFeatures = 12;
	localparam logic [HashW-1:0] HashMod = 30'd1000000007;
	localparam logic [5:0] HashBase = 6'd37;

	// Cycles from injecting a hash value into the chain until every maximum has settled.
	localparam int DrainLen = NumFeatures + 2;
	localparam int DrainW = $clog2(DrainLen + 1);

	typedef logic [FeatW-1:0] feat_word_t;
	typedef logic [HashW-1:0] drop_tab_t [256];

	localparam feat_word_t FeatMult [NumFeatures] = '{
		32'd999999761, 32'd999999797, 32'd999999883, 32'd999999893,
		32'd999999929, 32'd999999937, 32'd1000000007, 32'd1000000009,
		32'd1000000021, 32'd1000000033, 32'd1000000087, 32'd1000000093
	};

	localparam feat_word_t FeatAdd [NumFeatures] = '{
		32'd1000099, 32'd1000081, 32'd1000039, 32'd1000037,
		32'd1000033, 32'd1000003, 32'd999983, 32'd999979,
		32'd999961, 32'd999959, 32'd999953, 32'd999931
	};

	// Hash value travelling down the row of feature cells.
	typedef struct packed {
		logic             valid;
		logic [HashW-1:0] fp;
	} rhms_tap_t;

	// Reduces a value below 512p modulo p by restoring subtraction of p<<8 down to p.
	function automatic longint unsigned mod_prime(input longint unsigned x);
		longint unsigned r;
		r = x;
		for (int k = 8; k >= 0; k--) begin
			if (r >= (64'(HashMod) << k)) begin
				r = r - (64'(HashMod) << k);
			end
		end
		return r;
	endfunction

	// Table of b * 37^window mod p for every byte value b, built at elaboration.
	function automatic drop_tab_t make_drop_tab(input int window);
		drop_tab_t    tab;
		longint unsigned pw;
		pw = 64'd1;
		for (int i = 0; i < window; i++) begin
			pw = mod_prime(pw * 64'd37);
		end
		for (int b = 0; b < 256; b++) begin
			tab[b] = HashW'(mod_prime(64'(b) * pw));
		end
		return tab;
	endfunction

endpackage

### design/rhms_if.sv
// Valid/ready channel interfaces for the byte stream and the sketch result.
interface rhms_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

interface rhms_sketch_if;
	logic        valid;
	logic        ready;
	logic [31:0] feature_0;
	logic [31:0] feature_1;
	logic [31:0] feature_2;
	logic [31:0] feature_3;
	logic [31:0] feature_4;
	logic [31:0] feature_5;
	logic [31:0] feature_6;
	logic [31:0] feature_7;
	logic [31:0] feature_8;
	logic [31:0] feature_9;
	logic [31:0] feature_10;
	logic [31:0] feature_11;

	modport source (
		output valid, input ready,
		output feature_0, output feature_1, output feature_2, output feature_3,
		output feature_4, output feature_5, output feature_6, output feature_7,
		output feature_8, output feature_9, output feature_10, output feature_11
	);
	modport sink (
		input valid, output ready,
		input feature_0, input feature_1, input feature_2, input feature_3,
		input feature_4, input feature_5, input feature_6, input feature_7,
		input feature_8, input feature_9, input feature_10, input feature_11
	);
endinterface

### design/rhms_window_line.sv
// Byte shift line holding the hash window; the far end gives the byte leaving it.
module rhms_window_line #(
	parameter int Depth = 32
) (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	output logic [7:0] tail
);

	logic [7:0] line_q [Depth];

	always_ff @(posedge clk) begin
		if (shift) begin
			line_q[0] <= din;
			for (int i = 1; i < Depth; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign tail = line_q[Depth-1];

endmodule

### design/rhms_cell.sv
// One feature cell: applies its linear transform to the passing hash and keeps the maximum.
module rhms_cell import rhms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  rhms_tap_t  up,
	input  feat_word_t mult,
	input  feat_word_t add,
	output rhms_tap_t  down,
	output feat_word_t max_val
);

	feat_word_t       t_s1;
	logic             tv_s1;
	logic             pass_valid_s1;
	logic [HashW-1:0] pass_fp_s1;
	feat_word_t       max_q;
	feat_word_t       prod;

	// Only the low 32 bits of the transform matter, so the product is taken at 32 bits.
	assign prod = mult * {2'b00, up.fp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			pass_valid_s1 <= 1'b0;
			max_q <= '0;
		end else if (clear) begin
			tv_s1 <= 1'b0;
			pass_valid_s1 <= 1'b0;
			max_q <= '0;
		end else begin
			tv_s1 <= up.valid;
			pass_valid_s1 <= up.valid;
			if (tv_s1 && (t_s1 > max_q)) begin
				max_q <= t_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up.valid) begin
			t_s1 <= prod + add;
			pass_fp_s1 <= up.fp;
		end
	end

	assign down = '{valid: pass_valid_s1, fp: pass_fp_s1};
	assign max_val = max_q;

endmodule

### design/rolling_hash_max_sketch_top.sv
// Top level of the rolling hash resemblance sketch.
//
// The block takes a data block one byte per transfer on the stream channel; the byte
// flagged with block_end closes the block. It keeps a polynomial hash, base 37 modulo
// 1000000007, over the last WINDOW bytes. Once the window is full, every byte's hash is
// handed down a row of twelve feature cells, each applying its own transform m*fp+a and
// keeping the running maximum of the low 32 bits. On the closing byte the twelve maxima
// leave on the sketch channel as one transfer and all state returns to its reset values.
// A block shorter than the window yields a sketch of zeros.
//
// Each byte passes through the hash unit in order: its acceptance, a step to form
// 37*h + byte - drop term, and two-step restoring reduction modulo p from p<<5 down to p.
// The unit takes no new byte until the last one's hash is stored. After the closing byte
// its hash drains through the whole cell row before the sketch is loaded for output.
// Reset is asynchronous and clears the hash, the fill count and every maximum at once.
// A finished sketch waits in an output register; while it is stalled, bytes of the next
// block are still accepted, and only the following closing byte holds until it is taken.
module rolling_hash_max_sketch_top import rhms_pkg::*; #(
	parameter int WINDOW = 32
) (
	input logic                clk,
	input logic                arst_n,
	rhms_byte_if.sink          stream,
	rhms_sketch_if.source      sketch
);

	localparam int FillW = $clog2(WINDOW + 1);
	localparam drop_tab_t DropTab = make_drop_tab(WINDOW);
	localparam logic [35:0] Mod36 = 36'(HashMod);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SUM   = 5'b00010,
		S_RED   = 5'b00100,
		S_DRAIN = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [FillW-1:0] fill_q;
	logic [HashW-1:0] hash_q;
	logic [HashW-1:0] sub_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             feat_en_q;
	logic [35:0]      x_q;
	logic [1:0]       red_cnt_q;
	logic [DrainW-1:0] drain_q;
	logic             inj_valid_q;
	logic [HashW-1:0] inj_fp_q;
	logic             out_valid_q;
	feat_word_t       out_q [NumFeatures];

	logic             accept;
	logic             full;
	logic [7:0]       tail;
	logic [35:0]      red_next;
	logic             load_out;
	logic             cell_clear;
	rhms_tap_t        tap [NumFeatures+1];
	feat_word_t       max_w [NumFeatures];

	// Two steps of restoring reduction: subtract p shifted by the pair's amounts if it fits.
	function automatic logic [35:0] red_pair(input logic [35:0] x, input logic [1:0] step);
		logic [35:0] d_hi;
		logic [35:0] d_lo;
		logic [35:0] r;
		unique case (step)
			2'd0: begin
				d_hi = Mod36 << 5;
				d_lo = Mod36 << 4;
			end
			2'd1: begin
				d_hi = Mod36 << 3;
				d_lo = Mod36 << 2;
			end
			default: begin
				d_hi = Mod36 << 1;
				d_lo = Mod36;
			end
		endcase
		r = (x >= d_hi) ? x - d_hi : x;
		r = (r >= d_lo) ? r - d_lo : r;
		return r;
	endfunction

	assign full = (fill_q == FillW'(WINDOW));
	assign accept = stream.valid && stream.ready;
	assign stream.ready = (state_q == S_IDLE);
	assign red_next = red_pair(x_q, red_cnt_q);

	// The sketch is loaded once the row has settled and the output register is free.
	assign load_out = (state_q == S_EMIT) && (!out_valid_q || sketch.ready);
	assign cell_clear = load_out;

	rhms_window_line #(
		.Depth(WINDOW)
	) u_window (
		.clk  (clk),
		.shift(accept),
		.din  (stream.data_byte),
		.tail (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			hash_q <= '0;
			red_cnt_q <= '0;
			drain_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!full) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					red_cnt_q <= '0;
					state_q <= S_RED;
				end
				S_RED: begin
					red_cnt_q <= red_cnt_q + 1'b1;
					if (red_cnt_q == 2'd2) begin
						hash_q <= red_next[HashW-1:0];
						drain_q <= '0;
						state_q <= last_q ? S_DRAIN : S_IDLE;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == DrainW'(DrainLen - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load_out) begin
						fill_q <= '0;
						hash_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The hash enters the row for one cycle once it is reduced; the sketch stays valid
	// until it is taken, and a new sketch may replace it in the cycle it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			inj_valid_q <= (state_q == S_RED) && (red_cnt_q == 2'd2) && feat_en_q;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (sketch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the hash unit.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= stream.data_byte;
			last_q <= stream.block_end;
			// The window is full after this byte if it was full or one short of it.
			feat_en_q <= full || (fill_q == FillW'(WINDOW - 1));
			sub_q <= full ? DropTab[tail] : '0;
		end
		if (state_q == S_SUM) begin
			// Below 39p, so six conditional subtractions of p<<5 down to p suffice.
			x_q <= 36'(hash_q) * 36'(HashBase) + 36'(byte_q) + (Mod36 - 36'(sub_q));
		end else if (state_q == S_RED) begin
			x_q <= red_next;
		end
		if ((state_q == S_RED) && (red_cnt_q == 2'd2)) begin
			inj_fp_q <= red_next[HashW-1:0];
		end
		if (load_out) begin
			for (int j = 0; j < NumFeatures; j++) begin
				out_q[j] <= max_w[j];
			end
		end
	end

	// Row of feature cells; the hash moves one cell on in every cycle.
	assign tap[0] = '{valid: inj_valid_q, fp: inj_fp_q};

	for (genvar j = 0; j < NumFeatures; j++) begin : g_cell
		rhms_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (cell_clear),
			.up     (tap[j]),
			.mult   (FeatMult[j]),
			.add    (FeatAdd[j]),
			.down   (tap[j+1]),
			.max_val(max_w[j])
		);
	end

	assign sketch.valid = out_valid_q;
	assign sketch.feature_0 = out_q[0];
	assign sketch.feature_1 = out_q[1];
	assign sketch.feature_2 = out_q[2];
	assign sketch.feature_3 = out_q[3];
	assign sketch.feature_4 = out_q[4];
	assign sketch.feature_5 = out_q[5];
	assign sketch.feature_6 = out_q[6];
	assign sketch.feature_7 = out_q[7];
	assign sketch.feature_8 = out_q[8];
	assign sketch.feature_9 = out_q[9];
	assign sketch.feature_10 = out_q[10];
	assign sketch.feature_11 = out_q[11];

`ifndef SYNTHESIS
	// The stored hash is always fully reduced.
	a_hash_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		hash_q < HashMod)
		else $error("hash left unreduced");

	// The fill count saturates at the window length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(WINDOW))
		else $error("fill count beyond window");

	// When the sketch is loaded, no hash may still be travelling down the row.
	a_row_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !inj_valid_q && !tap[1].valid && !tap[NumFeatures].valid)
		else $error("sketch loaded before the cell row settled");

	// A byte is taken only when the previous one has left the hash unit.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SUM)
		else $error("accepted byte did not start the hash update");
`endif

endmodule
